@@ sv/stle_pkg.sv @@
// Package for the sorted task list engine: payload structs, codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package stle_pkg;
  localparam int DefCapacity = 32;
  localparam int IdW = 5;
  localparam int KeyW = 32;

  localparam logic [2:0] MODE_SORT_INS = 3'd0;
  localparam logic [2:0] MODE_CUR_INS  = 3'd1;
  localparam logic [2:0] MODE_REMOVE   = 3'd2;
  localparam logic [2:0] MODE_POP      = 3'd3;
  localparam logic [2:0] MODE_ADVANCE  = 3'd4;
  localparam logic [2:0] MODE_QUERY    = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [2:0]      mode;
    logic [IdW-1:0]  node_id;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [5:0]     entry_total;
    logic [IdW-1:0] result_node;
    logic           node_valid;
    logic           is_member;
    logic [2:0]     status;
  } out_item_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input transaction
    logic exec;   // apply list update, build result
  } ctl_cmd_t;
endpackage

@@ sv/stle_datapath.sv @@
// Datapath: slot array of cells with parallel compare and shift, cursor, flags.
// Depends on stle_pkg.
`timescale 1ns / 1ps
module stle_datapath #(
  parameter int Capacity = stle_pkg::DefCapacity,
  parameter int CntW = $clog2(Capacity + 1),
  parameter int PosW = $clog2(Capacity)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stle_pkg::ctl_cmd_t  cmd,
  input  stle_pkg::in_item_t  in_item,
  input  logic [31:0]         sentinel_key,
  output stle_pkg::out_item_t res
);
  import stle_pkg::*;
  localparam int NIds = 1 << IdW;

  logic [IdW-1:0]  ids_r  [Capacity];
  logic [KeyW-1:0] keys_r [Capacity];
  logic [CntW-1:0] cnt_r;
  logic [PosW-1:0] cur_r;
  logic            cur_sent_r;
  logic [NIds-1:0] mem_r;
  in_item_t        it_r;
  logic [KeyW-1:0] ksat_r;
  logic [Capacity-1:0] lt_r, hit_r;  // per cell: key < new key, id match

  // stage 1: capture and per-cell compare
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r   <= in_item;
      ksat_r <= (in_item.key > sentinel_key) ? sentinel_key : in_item.key;
      for (int i = 0; i < Capacity; i++) begin
        lt_r[i]  <= keys_r[i] < ((in_item.key > sentinel_key) ? sentinel_key : in_item.key);
        hit_r[i] <= ids_r[i] == in_item.node_id;
      end
    end
  end

  // stage 2: position select and shift
  logic [Capacity-1:0] live, ge_vec, hit_vec;
  logic [PosW-1:0] ins_pos, hit_pos, pos;
  logic [CntW-1:0] ins_full;
  logic            do_ins, do_take, found_ge;
  logic [CntW-1:0] cnt_nxt;
  logic [PosW-1:0] cur_nxt;
  logic            cur_sent_nxt;
  logic [2:0]      st;
  out_item_t       res_nxt;
  logic [CntW-1:0] pos_ext;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      live[i]    = CntW'(i) < cnt_r;
      ge_vec[i]  = live[i] & ~lt_r[i];
      hit_vec[i] = live[i] & hit_r[i];
    end
    found_ge = |ge_vec;
    ins_pos = '0;
    for (int i = Capacity - 1; i >= 0; i--) if (ge_vec[i]) ins_pos = PosW'(i);
    hit_pos = '0;
    for (int i = Capacity - 1; i >= 0; i--) if (hit_vec[i]) hit_pos = PosW'(i);
    // insert position may equal count (append)
    if (it_r.mode == MODE_SORT_INS) ins_full = found_ge ? CntW'(ins_pos) : cnt_r;
    else ins_full = cur_sent_r ? cnt_r : CntW'(cur_r);

    do_ins = 1'b0; do_take = 1'b0; st = ST_OK; pos = '0;
    cnt_nxt = cnt_r; cur_nxt = cur_r; cur_sent_nxt = cur_sent_r;
    res_nxt = '0;
    unique case (it_r.mode)
      MODE_SORT_INS, MODE_CUR_INS: begin
        if (mem_r[it_r.node_id]) st = ST_DUP;
        else if (cnt_r == CntW'(Capacity)) st = ST_FULL;
        else do_ins = 1'b1;
      end
      MODE_REMOVE: begin
        if (!mem_r[it_r.node_id]) st = ST_ABSENT;
        else begin do_take = 1'b1; pos = hit_pos; end
      end
      MODE_POP: begin
        if (cnt_r == '0) st = ST_EMPTY;
        else begin
          do_take = 1'b1;
          res_nxt.result_node = ids_r[0];
          res_nxt.node_valid = 1'b1;
        end
      end
      MODE_ADVANCE: begin
        if (cur_sent_r) begin
          if (cnt_r != '0) begin cur_sent_nxt = 1'b0; cur_nxt = '0; end
        end else if (CntW'(cur_r) + 1'b1 < cnt_r) cur_nxt = cur_r + 1'b1;
        else cur_nxt = '0;
      end
      MODE_QUERY: res_nxt.is_member = mem_r[it_r.node_id];
      default: ;
    endcase
    pos_ext = do_ins ? ins_full : CntW'(pos);
    if (do_ins) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!cur_sent_r && pos_ext <= CntW'(cur_r)) cur_nxt = cur_r + 1'b1;
    end
    if (do_take) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!cur_sent_r) begin
        if (cur_r == pos) begin
          if (pos == '0) begin cur_sent_nxt = 1'b1; cur_nxt = '0; end
          else cur_nxt = pos - 1'b1;
        end else if (cur_r > pos) cur_nxt = cur_r - 1'b1;
      end
    end
    res_nxt.status = st;
    res_nxt.entry_total = 6'(cnt_nxt);
  end

  // result cursor node from post-update array: computed combinationally from
  // the next slot contents
  logic [IdW-1:0]  ids_nxt  [Capacity];
  logic [KeyW-1:0] keys_nxt [Capacity];
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      ids_nxt[i] = ids_r[i]; keys_nxt[i] = keys_r[i];
      if (do_ins) begin
        if (CntW'(i) == pos_ext) begin
          ids_nxt[i] = it_r.node_id; keys_nxt[i] = ksat_r;
        end else if (CntW'(i) > pos_ext && i > 0) begin
          ids_nxt[i] = ids_r[(i > 0) ? i - 1 : 0];
          keys_nxt[i] = keys_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_take && CntW'(i) >= CntW'(pos) && i < Capacity - 1) begin
        ids_nxt[i] = ids_r[(i < Capacity - 1) ? i + 1 : i];
        keys_nxt[i] = keys_r[(i < Capacity - 1) ? i + 1 : i];
      end
    end
  end

  // final result: cursor node overrides unless this was a pop
  out_item_t res_fin;
  always_comb begin
    res_fin = res_nxt;
    if (it_r.mode != MODE_POP && !cur_sent_nxt && CntW'(cur_nxt) < cnt_nxt) begin
      res_fin.result_node = ids_nxt[cur_nxt];
      res_fin.node_valid  = 1'b1;
    end
  end

  out_item_t res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; cur_r <= '0; cur_sent_r <= 1'b1; mem_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt; cur_r <= cur_nxt; cur_sent_r <= cur_sent_nxt;
      if (do_ins) mem_r[it_r.node_id] <= 1'b1;
      if (do_take) mem_r[ids_r[pos]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < Capacity; i++) begin
        ids_r[i] <= ids_nxt[i]; keys_r[i] <= keys_nxt[i];
      end
      res_r <= res_fin;
    end
  end
  assign res = res_r;
endmodule

@@ sv/stle_ctrl.sv @@
// Controller FSM: load, execute, hold result until taken.
// Depends on stle_pkg.
`timescale 1ns / 1ps
module stle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output stle_pkg::ctl_cmd_t cmd
);
  import stle_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);
    out_valid = state_r == S_OUT;
    cmd.load  = in_ready && in_valid;
    cmd.exec  = state_r == S_EXEC;
  end
endmodule

@@ sv/sorted_task_list_engine_core.sv @@
// Top level of the sorted task list engine: controller plus slot datapath.
// Depends on stle_pkg, stle_ctrl, stle_datapath.
`timescale 1ns / 1ps
// Usage:
//  in_* channel: one transaction carries mode, node_id and key (in_item_t).
//  out_* channel: one result transaction per input transaction (out_item_t).
//  cfg_* channel: writes sentinel_key; always ready, write only while idle.
// Operation:
//  The first step captures the transaction and compares every slot key and
//  id in parallel. The second step picks the position by priority and shifts
//  the slot cells, updating cursor, count and membership. The result is then
//  held in an output register. No new item is taken while a result waits;
//  the next item can be taken in the same cycle as a result leaves.
// Reset (rst_n low, synchronous): list empty, cursor on the sentinel,
//  all membership flags clear, sentinel_key all ones. Slot contents are
//  not cleared; only slots below the count are ever read.
// Stall: while out_ready is low a waiting result holds and no input is taken.
module sorted_task_list_engine_core #(
  parameter int Capacity = stle_pkg::DefCapacity
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stle_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import stle_pkg::*;

  ctl_cmd_t    cmd;
  logic [31:0] sent_key_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) sent_key_r <= '1;
    else if (cfg_valid) sent_key_r <= cfg_data;
  end

  stle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  stle_datapath #(.Capacity(Capacity)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data),
    .sentinel_key(sent_key_r), .res(out_data)
  );
endmodule

@@ dv/sorted_task_list_engine_core_test.sv @@
// Testbench for sorted_task_list_engine_core: drives list operations through the
// in_/out_ handshakes, predicts every result with a behavioral list model.
// Depends on stle_pkg and the core RTL.
`timescale 1ns / 1ps
module sorted_task_list_engine_core_test;
  import stle_pkg::*;

  localparam int Cap = 32;
  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  always #10 clk = ~clk;

  sorted_task_list_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow list: compact slot array in list order plus cursor and membership.
  // ---------------------------------------------------------------------------
  logic [31:0]  lim_key;
  logic [4:0]   sh_ids [Cap];
  logic [31:0]  sh_keys [Cap];
  int           sh_count;
  int           sh_cur;
  bit           sh_on_sent;
  bit           sh_member [32];

  in_item_t  pending_ops[$];   // items waiting for the driver
  out_item_t expected_res[$];  // predicted results, oldest first
  int        fails = 0;
  int        idle_cycles = 0;
  bit        hold_off = 1'b0;  // long receiver stall request

  function automatic void list_place(input int pos, input logic [4:0] id,
                                     input logic [31:0] k);
    for (int i = sh_count; i > pos; i--) begin
      sh_ids[i] = sh_ids[i-1];
      sh_keys[i] = sh_keys[i-1];
    end
    sh_ids[pos] = id;
    sh_keys[pos] = k;
    if (!sh_on_sent && pos <= sh_cur) sh_cur++;
    sh_member[id] = 1'b1;
    sh_count++;
  endfunction

  function automatic void list_take(input int pos);
    sh_member[sh_ids[pos]] = 1'b0;
    if (!sh_on_sent) begin
      if (sh_cur == pos) begin
        if (pos == 0) begin
          sh_on_sent = 1'b1;
          sh_cur = 0;
        end else begin
          sh_cur = pos - 1;
        end
      end else if (sh_cur > pos) begin
        sh_cur--;
      end
    end
    for (int i = pos; i + 1 < sh_count; i++) begin
      sh_ids[i] = sh_ids[i+1];
      sh_keys[i] = sh_keys[i+1];
    end
    sh_count--;
  endfunction

  // Apply one operation to the shadow list and return the result it gives.
  function automatic out_item_t list_apply(input in_item_t op);
    out_item_t r;
    logic [31:0] k;
    int pos;
    bit popped;
    r = '0;
    popped = 1'b0;
    k = (op.key > lim_key) ? lim_key : op.key;
    r.status = ST_OK;
    case (op.mode)
      MODE_SORT_INS, MODE_CUR_INS: begin
        if (sh_member[op.node_id]) begin
          r.status = ST_DUP;
        end else if (sh_count >= Cap) begin
          r.status = ST_FULL;
        end else begin
          if (op.mode == MODE_SORT_INS) begin
            pos = 0;
            while (pos < sh_count && sh_keys[pos] < k) pos++;
          end else begin
            pos = sh_on_sent ? sh_count : sh_cur;
          end
          list_place(pos, op.node_id, k);
        end
      end
      MODE_REMOVE: begin
        if (!sh_member[op.node_id]) begin
          r.status = ST_ABSENT;
        end else begin
          pos = 0;
          while (sh_ids[pos] != op.node_id) pos++;
          list_take(pos);
        end
      end
      MODE_POP: begin
        popped = 1'b1;
        if (sh_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_node = sh_ids[0];
          r.node_valid = 1'b1;
          list_take(0);
        end
      end
      MODE_ADVANCE: begin
        if (sh_on_sent) begin
          if (sh_count > 0) begin
            sh_on_sent = 1'b0;
            sh_cur = 0;
          end
        end else if (sh_cur + 1 < sh_count) begin
          sh_cur++;
        end else begin
          sh_cur = 0;
        end
      end
      MODE_QUERY: r.is_member = sh_member[op.node_id];
      default: ;
    endcase
    if (!popped && !sh_on_sent && sh_cur < sh_count) begin
      r.result_node = sh_ids[sh_cur];
      r.node_valid = 1'b1;
    end
    r.entry_total = 6'(sh_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued transactions, random gaps; changes on falling edge.
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  bit in_ready_seen = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_seen) begin
        // transaction taken at the last rising edge
        if (pending_ops.size() > 0 && in_gap == 0) begin
          in_data <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_ops.size() > 0) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Draw a gap for each item; mostly none, sometimes short, rarely long.
  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sample handshakes at the rising edge; predict on input acceptance.
  always @(posedge clk) begin
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_res.push_back(list_apply(in_data));
      in_gap <= draw_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each result transaction with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        fails++;
      end else begin
        exp_r = expected_res.pop_front();
        if (out_data.entry_total !== exp_r.entry_total)
          $display("%0t: entry_total exp %0d got %0d", $time, exp_r.entry_total,
                   out_data.entry_total);
        if (out_data.result_node !== exp_r.result_node)
          $display("%0t: result_node exp %0d got %0d", $time, exp_r.result_node,
                   out_data.result_node);
        if (out_data.node_valid !== exp_r.node_valid)
          $display("%0t: node_valid exp %0d got %0d", $time, exp_r.node_valid,
                   out_data.node_valid);
        if (out_data.is_member !== exp_r.is_member)
          $display("%0t: is_member exp %0d got %0d", $time, exp_r.is_member,
                   out_data.is_member);
        if (out_data.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_data.status);
        if (out_data !== exp_r) fails++;
      end
    end
  end

  // Result taken at the last rising edge.
  bit out_taken = 1'b0;
  always @(posedge clk) begin
    out_taken <= rst_n && out_valid && out_ready;
  end

  // Receiver stalls: random ready, or held low during a requested hold-off.
  int out_gap = 0;
  always @(negedge clk) begin
    int g;
    if (hold_off || !rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (out_taken) begin
      g = draw_gap();
      out_gap <= (g > 0) ? g - 1 : 0;
      out_ready <= (g == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("sorted_task_list_engine_core_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_op(input logic [2:0] m, input logic [4:0] id,
                                     input logic [31:0] k);
    in_item_t t;
    t.mode = m;
    t.node_id = id;
    t.key = k;
    return t;
  endfunction

  // Keys: mix of small values, near the sentinel, extremes and full random.
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return lim_key - $urandom_range(0, 3);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Random mode: fill_bias sets the share of inserts; the rest mixes other modes.
  function automatic in_item_t rand_op(input int fill_bias);
    int p;
    logic [2:0] m;
    p = $urandom_range(0, 99);
    if (p < fill_bias) m = ($urandom_range(0, 1) == 0) ? MODE_SORT_INS : MODE_CUR_INS;
    else if (p < 70) m = 3'($urandom_range(2, 5));
    else if (p < 96) m = 3'($urandom_range(0, 5));
    else m = 3'($urandom_range(6, 7));
    return mk_op(m, 5'($urandom_range(0, 31)), rand_key());
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_key = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] limits [4];
    lim_key = 32'hFFFF_FFFF;
    sh_count = 0;
    sh_cur = 0;
    sh_on_sent = 1'b1;
    foreach (sh_member[i]) sh_member[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, both inserts, dup, absent, cursor wrap, saturation.
    pending_ops.push_back(mk_op(MODE_POP, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_ADVANCE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_REMOVE, 5'd31, 32'd0));
    pending_ops.push_back(mk_op(MODE_SORT_INS, 5'd31, 32'hFFFF_FFFF));
    pending_ops.push_back(mk_op(MODE_SORT_INS, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_SORT_INS, 5'd0, 32'd5));
    pending_ops.push_back(mk_op(MODE_CUR_INS, 5'd7, 32'd100));
    pending_ops.push_back(mk_op(MODE_ADVANCE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_CUR_INS, 5'd9, 32'd3));
    pending_ops.push_back(mk_op(MODE_ADVANCE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_ADVANCE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_ADVANCE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_ADVANCE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_QUERY, 5'd9, 32'd0));
    pending_ops.push_back(mk_op(MODE_QUERY, 5'd10, 32'd0));
    pending_ops.push_back(mk_op(3'd6, 5'd1, 32'd1));
    pending_ops.push_back(mk_op(3'd7, 5'd2, 32'd2));
    pending_ops.push_back(mk_op(MODE_REMOVE, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_POP, 5'd0, 32'd0));
    // Fill to capacity, then further inserts of ids 3 and 4 around a pop.
    for (int i = 0; i < 32; i++)
      pending_ops.push_back(mk_op(MODE_SORT_INS, 5'(i), $urandom));
    pending_ops.push_back(mk_op(MODE_CUR_INS, 5'd3, 32'd1));
    pending_ops.push_back(mk_op(MODE_POP, 5'd0, 32'd0));
    pending_ops.push_back(mk_op(MODE_CUR_INS, 5'd3, 32'd1));
    pending_ops.push_back(mk_op(MODE_CUR_INS, 5'd4, 32'd1));

    // Receiver holds off while the sender keeps offering: input must stall.
    hold_off = 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
    wait_drained();

    // Random phases under several sentinel settings, extremes included.
    limits[0] = 32'd0;
    limits[1] = 32'd1000;
    limits[2] = $urandom;
    limits[3] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < 300; n++)
        pending_ops.push_back(rand_op((n / 50) % 2 == 0 ? 55 : 20));
      wait_drained();
    end

    if (fails == 0 && expected_res.size() == 0) begin
      $display("sorted_task_list_engine_core_test: PASS");
    end else begin
      $display("sorted_task_list_engine_core_test: FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/stle_pkg.sv
sv/stle_datapath.sv
sv/stle_ctrl.sv
sv/sorted_task_list_engine_core.sv
dv/sorted_task_list_engine_core_test.sv
